### src/histogram_largest_rectangle_unit_defines.svh
// Assertion macros shared by the largest-rectangle unit.
`ifndef HISTOGRAM_LARGEST_RECTANGLE_UNIT_DEFINES_SVH
`define HISTOGRAM_LARGEST_RECTANGLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HLR_ASSERT_ALWAYS(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("assertion failed");
`define HLR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HLR_ASSERT_ALWAYS(lbl, ck, rn, cond)
`define HLR_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### src/hlr_pkg.sv
// Shared constants and types of the largest-rectangle unit.
package hlr_pkg;

	localparam int MAX_BARS    = 1024;
	localparam int HEIGHT_BITS = 32;
	localparam int AREA_BITS   = 42;
	localparam int ADDR_W      = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int POS_W       = $clog2(MAX_BARS + 1);
	localparam int PROD_W      = HEIGHT_BITS + POS_W;

	typedef struct packed {
		logic [HEIGHT_BITS-1:0] height;
		logic [ADDR_W-1:0]      start;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one popped entry going to the area unit
	typedef struct packed {
		logic                   vld;
		logic [HEIGHT_BITS-1:0] height;
		logic [POS_W-1:0]       width;
	} pop_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DRAIN,
		S_OUT
	} state_t;

endpackage

### src/histogram_largest_rectangle_unit.sv
// Largest rectangle in a histogram: bar stream in, best area out at the last bar.
// Per bar: accept it, pop each stack entry not lower than it, then push it.
// Every bar is popped at most once. After the last bar the remaining entries
// are drained, the last product is compared, and the output register is loaded.
// The pop loop is paced by the single stack memory read port (one entry per cycle).
// Async reset clears control and the best area; the stack memory is never cleared.
`include "histogram_largest_rectangle_unit_defines.svh"

module histogram_largest_rectangle_unit
	import hlr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          bar_height,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [AREA_BITS-1:0] max_area,
	output logic                 too_many_bars
);

	// ------------------------------------------------------------------
	// State: the top of stack lives in registers, every entry below it
	// lives in the stack memory. The memory read address always tracks
	// the entry just below the next top, so a pop finds its successor
	// already read out.
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [POS_W-1:0]       depth_q, depth_d;
	logic [POS_W-1:0]       pos_q;
	logic                   ovf_q;
	entry_t                 top_q;
	logic [HEIGHT_BITS-1:0] h_q;
	logic [ADDR_W-1:0]      start_q;
	logic                   last_q;

	logic                   out_valid_q;
	logic [PROD_W-1:0]      out_area_q;
	logic                   out_flag_q;

	logic accept;
	logic pop_ok;
	logic pop_en;
	logic push_en;
	logic seq_done;
	logic out_free;
	logic at_limit;

	// stack memory ports
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_data;
	entry_t            below;

	// forwarding of a write that hits the address being read
	logic   fwd_hit_q;
	entry_t fwd_data_q;

	pop_req_t          req;
	logic [PROD_W-1:0] best;

	assign accept   = in_valid && in_ready;
	assign at_limit = (pos_q == POS_W'(MAX_BARS));
	assign pop_ok   = (depth_q != '0) && (top_q.height >= h_q);
	assign out_free = !out_valid_q || out_ready;

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (at_limit) begin
						state_d = is_last ? S_DRAIN : S_IDLE;
					end else begin
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				if (!pop_ok) begin
					state_d = last_q ? S_DRAIN : S_IDLE;
				end
			end
			S_DRAIN: begin
				// the last product is compared in this cycle
				if (depth_q == '0) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: control outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_ready = 1'b0;
		pop_en   = 1'b0;
		push_en  = 1'b0;
		seq_done = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_POP: begin
				pop_en  = pop_ok;
				push_en = !pop_ok;
			end
			S_DRAIN: pop_en   = (depth_q != '0);
			S_OUT:   seq_done = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Stack depth and memory addressing
	// ------------------------------------------------------------------
	always_comb begin
		depth_d = depth_q;
		if (pop_en) begin
			depth_d = depth_q - POS_W'(1);
		end else if (push_en) begin
			depth_d = depth_q + POS_W'(1);
		end
	end

	// old top moves into memory on a push
	assign wr_en   = push_en && (depth_q != '0);
	assign wr_addr = ADDR_W'(depth_q - POS_W'(1));
	assign rd_addr = ADDR_W'(depth_d - POS_W'(2));

	hlr_stack_ram #(
		.DATA_W (ENTRY_W),
		.ADDR_W (ADDR_W),
		.DEPTH  (MAX_BARS)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (top_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= top_q;
	end

	assign below = fwd_hit_q ? fwd_data_q : rd_data;

	// ------------------------------------------------------------------
	// Bar intake, stack update, position and overflow
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			depth_q <= depth_d;
			if (accept) begin
				last_q <= is_last;
				if (at_limit) begin
					ovf_q <= 1'b1;
				end
			end
			if (push_en) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (seq_done) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q     <= HEIGHT_BITS'(bar_height);
			start_q <= ADDR_W'(pos_q);
		end else if (pop_en) begin
			// the new bar's rectangle reaches back to the popped start
			start_q <= top_q.start;
		end
		if (pop_en) begin
			top_q <= below;
		end else if (push_en) begin
			top_q <= '{height: h_q, start: start_q};
		end
	end

	// ------------------------------------------------------------------
	// Area of each popped entry: height times (position - start)
	// ------------------------------------------------------------------
	assign req.vld    = pop_en;
	assign req.height = top_q.height;
	assign req.width  = pos_q - POS_W'(top_q.start);

	hlr_area_unit u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.clear  (seq_done),
		.best   (best)
	);

	// ------------------------------------------------------------------
	// Output register: holds the result while a new sequence starts
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_area_q <= best;
			out_flag_q <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign max_area      = AREA_BITS'(out_area_q);
	assign too_many_bars = out_flag_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`HLR_ASSERT_ALWAYS(a_no_pop_push, clk, arst_n, !(pop_en && push_en))
	`HLR_ASSERT_ALWAYS(a_depth_le_pos, clk, arst_n, depth_q <= pos_q)
	`HLR_ASSERT_ALWAYS(a_empty_at_out, clk, arst_n, (state_q != S_OUT) || (depth_q == '0))
	`HLR_ASSERT_NEXT(a_done_loads_out, clk, arst_n, seq_done, out_valid_q && (pos_q == '0))

endmodule

### src/hlr_stack_ram.sv
// Stack storage: one write port, one registered read port.
module hlr_stack_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4,
	parameter int DEPTH  = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/hlr_area_unit.sv
// Area multiply stage and running maximum.
module hlr_area_unit
	import hlr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  pop_req_t          req,
	input  logic              clear,
	output logic [PROD_W-1:0] best
);

	logic              vld_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W-1:0] best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld) begin
			prod_s1 <= PROD_W'(req.height) * PROD_W'(req.width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clear) begin
			best_q <= '0;
		end else if (vld_s1 && (prod_s1 > best_q)) begin
			best_q <= prod_s1;
		end
	end

	assign best = best_q;

endmodule

### dv/tb.sv
// Self-checking testbench for the histogram largest-rectangle unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hlr_pkg::*;

	// Run-level knobs
	localparam int RANDOM_BARS   = 950;  // rough size of the random part
	localparam int HOLD_AT_BAR   = 1400; // input transfer count that starts the long sink stall
	localparam int HOLD_CYCLES   = 3000; // length of that stall
	localparam int SETTLE_CYCLES = 20;   // quiet time after the last result
	localparam int MAX_PRINTED   = 100;  // cap on printed mismatch lines

	// What the filler wants the bars of a sequence to look like
	typedef enum int {
		H_WIDE,   // full 32-bit random heights
		H_NARROW, // tiny range, lots of equal neighbors
		H_RAMP,   // monotone run up or down
		H_EDGE    // only zero, all ones, or random
	} height_style_t;

	// One bar waiting in the send queue
	typedef struct {
		logic [31:0] height;
		logic        last;
		int          gap;  // cycles to idle before offering it
		bit          sync; // hold it back until every result is in
	} bar_item_t;

	// One expected result
	typedef struct {
		logic [AREA_BITS-1:0] area;
		logic                 overflow;
	} area_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [31:0]          bar_height    = '0;
	logic                 is_last       = 1'b0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [AREA_BITS-1:0] max_area;
	logic                 too_many_bars;

	histogram_largest_rectangle_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.bar_height    (bar_height),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.max_area      (max_area),
		.too_many_bars (too_many_bars)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Area predictor: a private monotonic stack of (height, start index)
	// ------------------------------------------------------------------
	logic [HEIGHT_BITS-1:0] run_height [MAX_BARS];
	int unsigned            run_start  [MAX_BARS];
	int unsigned            run_depth   = 0;
	int unsigned            bars_seen   = 0; // bars entered in this sequence
	longint unsigned        best_so_far = 0;
	bit                     overflowed  = 1'b0;

	area_result_t expected_areas[$];

	int errors = 0;

	// Score the rectangle of one popped entry that reaches up to bar index stop.
	function automatic void close_run(logic [HEIGHT_BITS-1:0] h, int unsigned first,
			int unsigned stop);
		longint unsigned a;
		a = longint'(h) * longint'(stop - first);
		if (a > best_so_far)
			best_so_far = a;
	endfunction

	// Feed one transferred bar into the predictor; queue a result on the last bar.
	function automatic void predict_bar(logic [31:0] raw, logic last);
		logic [HEIGHT_BITS-1:0] h;
		int unsigned            first;
		area_result_t           r;
		h = raw[HEIGHT_BITS-1:0];
		if (bars_seen < MAX_BARS) begin
			first = bars_seen;
			// pop everything not lower than the new bar; it inherits the oldest start
			while (run_depth > 0 && run_height[run_depth-1] >= h) begin
				run_depth--;
				close_run(run_height[run_depth], run_start[run_depth], bars_seen);
				first = run_start[run_depth];
			end
			run_height[run_depth] = h;
			run_start[run_depth]  = first;
			run_depth++;
			bars_seen++;
		end else begin
			// bar past the capacity: dropped, only flagged
			overflowed = 1'b1;
		end
		if (last) begin
			while (run_depth > 0) begin
				run_depth--;
				close_run(run_height[run_depth], run_start[run_depth], bars_seen);
			end
			r.area     = best_so_far[AREA_BITS-1:0];
			r.overflow = overflowed;
			expected_areas.push_back(r);
			// next bar opens a fresh sequence
			run_depth   = 0;
			bars_seen   = 0;
			best_so_far = 0;
			overflowed  = 1'b0;
		end
	endfunction

	task automatic report_mismatch(string msg);
		if (errors < MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus store, filled up front by the initial block below
	// ------------------------------------------------------------------
	bar_item_t bar_q[$];
	bit        fill_calm = 1'b0; // no idling for the bars being added
	bit        fill_sync = 1'b0; // next added bar waits for an empty scoreboard

	task automatic add_bar(logic [31:0] h, logic last);
		bar_item_t it;
		it.height = h;
		it.last   = last;
		it.gap    = fill_calm ? 0 : $urandom_range(0, 11);
		it.sync   = fill_sync;
		fill_sync = 1'b0;
		bar_q.push_back(it);
	endtask

	// ------------------------------------------------------------------
	// Driver: pulls bars from bar_q, idles the drawn gap, then holds valid
	// until the transfer. Prediction happens on the transfer edge.
	// ------------------------------------------------------------------
	bar_item_t cur_bar;
	bit        bar_loaded = 1'b0;
	int        gap_left   = 0;
	int        bars_sent  = 0;

	always @(posedge clk) begin
		logic next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				predict_bar(bar_height, is_last);
				bars_sent++;
				next_valid = 1'b0;
				bar_loaded = 1'b0;
			end
			if (!next_valid) begin
				if (!bar_loaded && bar_q.size() > 0) begin
					cur_bar    = bar_q.pop_front();
					bar_loaded = 1'b1;
					gap_left   = cur_bar.gap;
				end
				if (bar_loaded) begin
					if (cur_bar.sync && expected_areas.size() > 0) begin
						// paused until the block has handed back everything
					end else if (gap_left > 0) begin
						gap_left--;
					end else begin
						next_valid = 1'b1;
						bar_height <= cur_bar.height;
						is_last    <= cur_bar.last;
						cur_bar.sync = 1'b0;
					end
				end
			end
			// single write per edge so valid never glitches between back-to-back bars
			in_valid <= next_valid;
		end
	end

	// ------------------------------------------------------------------
	// Long sink stall: once, ready is held low for many cycles while the
	// driver keeps offering bars, so the block backs up into its input.
	// ------------------------------------------------------------------
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && bars_sent >= HOLD_AT_BAR) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest prediction
	// and paces out_ready.
	// ------------------------------------------------------------------
	int rx_wait      = 0;
	int rx_calm_left = 0; // results still to take without any wait

	always @(posedge clk) begin
		logic         next_ready;
		area_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_areas.size() == 0) begin
					report_mismatch($sformatf("result area %0d with nothing expected", max_area));
				end else begin
					want = expected_areas.pop_front();
					if (max_area !== want.area)
						report_mismatch($sformatf("max_area %0d, expected %0d",
							max_area, want.area));
					if (too_many_bars !== want.overflow)
						report_mismatch($sformatf("too_many_bars %0b, expected %0b",
							too_many_bars, want.overflow));
				end
				// draw the wait before taking the next result
				if (rx_calm_left > 0) begin
					rx_calm_left--;
					rx_wait = 0;
				end else if ($urandom_range(0, 5) == 0) begin
					rx_calm_left = 15;
					rx_wait      = 0;
				end else begin
					rx_wait = $urandom_range(0, 11);
				end
			end else if (out_ready && rx_calm_left == 0 && $urandom_range(0, 15) == 0) begin
				// occasional drop while idle so stalls land on any phase of the work
				rx_wait = $urandom_range(1, 11);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				next_ready = 1'b0;
			end else begin
				next_ready = (hold_left == 0);
			end
			out_ready <= next_ready;
		end
	end

	// ------------------------------------------------------------------
	// Run control: build all stimulus, reset, wait for the drain, judge.
	// ------------------------------------------------------------------
	initial begin
		int            i;
		int            len;
		int            random_count;
		height_style_t style;
		logic [31:0]   h;
		logic [31:0]   base;
		bit            up;

		// Directed: single bars at both extremes
		add_bar(32'h0, 1'b1);
		add_bar(32'hFFFF_FFFF, 1'b1);
		// two tallest bars: widest area at full height
		add_bar(32'hFFFF_FFFF, 1'b0);
		add_bar(32'hFFFF_FFFF, 1'b1);
		// equal heights pop each other
		add_bar(32'd5, 1'b0);
		add_bar(32'd5, 1'b0);
		add_bar(32'd5, 1'b1);
		// rising then falling staircases
		for (i = 1; i <= 4; i++)
			add_bar(i, 1'b0);
		for (i = 4; i >= 1; i--)
			add_bar(i, i == 1);
		// textbook mix
		add_bar(32'd2, 1'b0);
		add_bar(32'd1, 1'b0);
		add_bar(32'd5, 1'b0);
		add_bar(32'd6, 1'b0);
		add_bar(32'd2, 1'b0);
		add_bar(32'd3, 1'b1);
		// tall spike between zeros, then alternating bit patterns
		add_bar(32'h0, 1'b0);
		add_bar(32'hFFFF_FFFF, 1'b0);
		add_bar(32'h0, 1'b1);
		add_bar(32'hAAAA_AAAA, 1'b0);
		add_bar(32'h5555_5555, 1'b1);

		// Full stack, then overflow: strictly rising near the top of the height
		// range fills every entry with an area close to the widest field value;
		// two more bars pass capacity, the last one among them.
		// Sender waits for an empty scoreboard first.
		fill_sync = 1'b1;
		for (i = 0; i < MAX_BARS + 2; i++)
			add_bar(32'hFFFF_FC00 + i, i == MAX_BARS + 1);

		// Random sequences, mostly short, a few up to 64 bars
		random_count = 0;
		while (random_count < RANDOM_BARS) begin
			len       = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
				: $urandom_range(1, 12);
			style     = height_style_t'($urandom_range(0, 3));
			fill_calm = ($urandom_range(0, 3) == 0);
			fill_sync = ($urandom_range(0, 24) == 0);
			base      = $urandom;
			up        = $urandom_range(0, 1);
			for (i = 0; i < len; i++) begin
				case (style)
					H_WIDE:   h = $urandom;
					H_NARROW: h = $urandom_range(0, 7);
					H_RAMP:   h = up ? base + i * $urandom_range(0, 3)
						: base - i * $urandom_range(0, 3);
					default: begin
						case ($urandom_range(0, 2))
							0:       h = 32'h0;
							1:       h = 32'hFFFF_FFFF;
							default: h = $urandom;
						endcase
					end
				endcase
				add_bar(h, i == len - 1);
			end
			random_count += len;
		end
		fill_calm = 1'b0;
		len = bar_q.size();

		// Reset held from the start, released on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bars_sent < len)
			@(posedge clk);
		while (expected_areas.size() != 0)
			@(posedge clk);
		// watch for stray results after the last one
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
